// File: hw/rtl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Types and widths shared by the rotation matrix to quaternion converter.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = DATA_WIDTH - 2;
  localparam int ARG_W      = DATA_WIDTH + 3;
  localparam int POS_W      = DATA_WIDTH + 1;
  localparam int MAG_W      = DATA_WIDTH + 1;
  localparam int ROOT_W     = DATA_WIDTH;
  localparam int RAD_W      = 2 * DATA_WIDTH;
  localparam int REM_W      = ROOT_W + 2;
  localparam int NUM_W      = 2 * DATA_WIDTH - 1;
  localparam int DREM_W     = ROOT_W + 1;
  localparam int FIFO_DEPTH = 2;

  typedef logic signed [DATA_WIDTH-1:0] fix_t;

  typedef struct packed {
    fix_t m00;
    fix_t m01;
    fix_t m02;
    fix_t m10;
    fix_t m11;
    fix_t m12;
    fix_t m20;
    fix_t m21;
    fix_t m22;
  } rmq_in_t;

  typedef struct packed {
    fix_t q_w;
    fix_t q_x;
    fix_t q_y;
    fix_t q_z;
    logic degenerate;
  } rmq_out_t;

  // classified request: root argument, degenerate flag, main slot, and sign and magnitude of the three parts
  typedef struct packed {
    logic [POS_W-1:0]            arg;
    logic                        degen;
    logic [1:0]                  main_slot;
    logic [2:0]                  neg;
    logic [2:0][MAG_W-1:0]       mag;
  } rmq_cls_t;

endpackage

// File: hw/rtl/rmq_front.sv
// ----------------------------------------------------------------------------
// rmq_front
// Accepts a matrix, picks the branch and main component, forms the root
// argument and the three off-diagonal sums or differences.
// ----------------------------------------------------------------------------
module rmq_front import rmq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  rmq_in_t  in_data,
  output logic     push_valid,
  input  logic     push_ready,
  output rmq_cls_t push_data
);

  localparam logic signed [ARG_W-1:0] ONE_FIX =
    {{(ARG_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  logic signed [ARG_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [ARG_W-1:0] trace, arg;
  logic signed [ARG_W-1:0] d [3];
  logic [1:0]              main_slot;
  logic                    degen;
  rmq_cls_t                cls_nxt;
  rmq_cls_t                cls_r;
  logic                    v_r;

  assign e00 = ARG_W'(in_data.m00);
  assign e01 = ARG_W'(in_data.m01);
  assign e02 = ARG_W'(in_data.m02);
  assign e10 = ARG_W'(in_data.m10);
  assign e11 = ARG_W'(in_data.m11);
  assign e12 = ARG_W'(in_data.m12);
  assign e20 = ARG_W'(in_data.m20);
  assign e21 = ARG_W'(in_data.m21);
  assign e22 = ARG_W'(in_data.m22);
  assign trace = e00 + e11 + e22;

  always_comb begin
    if (trace > 0) begin
      main_slot = 2'd0;
    end else if (e22 > ((e11 > e00) ? e11 : e00)) begin
      main_slot = 2'd3;
    end else if (e11 > e00) begin
      main_slot = 2'd2;
    end else begin
      main_slot = 2'd1;
    end
    unique case (main_slot)
      2'd0: begin
        arg  = trace + ONE_FIX;
        d[0] = e21 - e12;
        d[1] = e02 - e20;
        d[2] = e10 - e01;
      end
      2'd1: begin
        arg  = e00 - e11 - e22 + ONE_FIX;
        d[0] = e21 - e12;
        d[1] = e10 + e01;
        d[2] = e20 + e02;
      end
      2'd2: begin
        arg  = e11 - e22 - e00 + ONE_FIX;
        d[0] = e02 - e20;
        d[1] = e01 + e10;
        d[2] = e21 + e12;
      end
      default: begin
        arg  = e22 - e00 - e11 + ONE_FIX;
        d[0] = e10 - e01;
        d[1] = e02 + e20;
        d[2] = e12 + e21;
      end
    endcase
    degen = (arg <= 0);
    cls_nxt.arg       = POS_W'(arg);
    cls_nxt.degen     = degen;
    cls_nxt.main_slot = main_slot;
    for (int n = 0; n < 3; n++) begin
      cls_nxt.neg[n] = d[n][ARG_W-1];
      cls_nxt.mag[n] = d[n][ARG_W-1] ? MAG_W'(-d[n]) : MAG_W'(d[n]);
    end
  end

  assign in_ready   = !v_r || push_ready;
  assign push_valid = v_r;
  assign push_data  = cls_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      v_r <= 1'b1;
    end else if (push_ready) begin
      v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cls_r <= cls_nxt;
    end
  end

endmodule

// File: hw/rtl/rmq_fifo.sv
// ----------------------------------------------------------------------------
// rmq_fifo
// Short queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module rmq_fifo import rmq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  rmq_cls_t push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output rmq_cls_t pop_data
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  rmq_cls_t         mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != CNT_W'(FIFO_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(FIFO_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(FIFO_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: hw/rtl/rmq_back.sv
// ----------------------------------------------------------------------------
// rmq_back
// Pipelined square root (one root bit per stage), then three pipelined
// dividers (one quotient bit per stage), then rounding, saturation and
// placement of the four components.
// ----------------------------------------------------------------------------
module rmq_back import rmq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     pop_valid,
  output logic     pop_ready,
  input  rmq_cls_t pop_data,
  output logic     out_valid,
  input  logic     out_ready,
  output rmq_out_t out_data
);

  localparam fix_t SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam fix_t SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic en;

  logic                  sq_v_r   [0:ROOT_W];
  rmq_cls_t              sq_cls_r [0:ROOT_W];
  logic [RAD_W-1:0]      sq_rad_r [0:ROOT_W];
  logic [REM_W-1:0]      sq_rem_r [0:ROOT_W];
  logic [ROOT_W-1:0]     sq_res_r [0:ROOT_W];

  logic                  dv_v_r    [0:NUM_W];
  rmq_cls_t              dv_cls_r  [0:NUM_W];
  logic [ROOT_W-1:0]     dv_root_r [0:NUM_W];
  logic [2:0][NUM_W-1:0] dv_q_r    [0:NUM_W];
  logic [2:0][DREM_W-1:0] dv_rem_r [0:NUM_W];

  logic [2:0][NUM_W-1:0] num_nxt;
  rmq_out_t              out_nxt;
  rmq_out_t              out_r;
  logic                  out_v_r;

  assign en        = !out_v_r || out_ready;
  assign pop_ready = en;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // square root entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (en) begin
      sq_v_r[0] <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_cls_r[0] <= pop_data;
      sq_rad_r[0] <= RAD_W'(pop_data.arg) << FRAC_BITS;
      sq_rem_r[0] <= '0;
      sq_res_r[0] <= '0;
    end
  end

  for (genvar s = 0; s < ROOT_W; s++) begin : g_sqrt
    logic [REM_W+1:0] tmp, trial;
    logic             ge;

    assign tmp   = {sq_rem_r[s], sq_rad_r[s][RAD_W-1 -: 2]};
    assign trial = (REM_W+2)'({sq_res_r[s], 2'b01});
    assign ge    = (tmp >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[s+1] <= 1'b0;
      end else if (en) begin
        sq_v_r[s+1] <= sq_v_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_cls_r[s+1] <= sq_cls_r[s];
        sq_rad_r[s+1] <= {sq_rad_r[s][RAD_W-3:0], 2'b00};
        sq_rem_r[s+1] <= ge ? REM_W'(tmp - trial) : REM_W'(tmp);
        sq_res_r[s+1] <= {sq_res_r[s][ROOT_W-2:0], ge};
      end
    end
  end

  // divider entry: |s| * 2^(F-1) + root/2
  always_comb begin
    for (int n = 0; n < 3; n++) begin
      num_nxt[n] = (NUM_W'(sq_cls_r[ROOT_W].mag[n]) << (FRAC_BITS-1))
                 + NUM_W'(sq_res_r[ROOT_W] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= sq_v_r[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_cls_r[0]  <= sq_cls_r[ROOT_W];
      dv_root_r[0] <= sq_res_r[ROOT_W];
      dv_q_r[0]    <= num_nxt;
      dv_rem_r[0]  <= '0;
    end
  end

  for (genvar d = 0; d < NUM_W; d++) begin : g_div
    logic [2:0][DREM_W:0]   tmp;
    logic [2:0]             ge;
    logic [2:0][DREM_W-1:0] rem_nxt;
    logic [2:0][NUM_W-1:0]  q_nxt;

    always_comb begin
      for (int n = 0; n < 3; n++) begin
        tmp[n]     = {dv_rem_r[d][n], dv_q_r[d][n][NUM_W-1]};
        ge[n]      = (tmp[n] >= (DREM_W+1)'(dv_root_r[d]));
        rem_nxt[n] = ge[n] ? DREM_W'(tmp[n] - (DREM_W+1)'(dv_root_r[d]))
                           : DREM_W'(tmp[n]);
        q_nxt[n]   = {dv_q_r[d][n][NUM_W-2:0], ge[n]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[d+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[d+1] <= dv_v_r[d];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_cls_r[d+1]  <= dv_cls_r[d];
        dv_root_r[d+1] <= dv_root_r[d];
        dv_q_r[d+1]    <= q_nxt;
        dv_rem_r[d+1]  <= rem_nxt;
      end
    end
  end

  // rounding, saturation, slot placement
  always_comb begin
    logic [ROOT_W:0] half;
    fix_t            main_v;
    fix_t            part [3];
    fix_t            slot [4];
    logic [NUM_W-1:0] q;
    int              idx;

    half   = ({1'b0, dv_root_r[NUM_W]} + 1'b1) >> 1;
    main_v = (half > (ROOT_W+1)'(SAT_MAX)) ? SAT_MAX : fix_t'(half);
    for (int n = 0; n < 3; n++) begin
      q = dv_q_r[NUM_W][n];
      if (q[NUM_W-1:DATA_WIDTH-1] != '0) begin
        part[n] = dv_cls_r[NUM_W].neg[n] ? SAT_MIN : SAT_MAX;
      end else begin
        part[n] = dv_cls_r[NUM_W].neg[n] ? fix_t'(-q[DATA_WIDTH-1:0])
                                         : fix_t'(q[DATA_WIDTH-1:0]);
      end
    end
    idx = 0;
    for (int t = 0; t < 4; t++) begin
      if (dv_cls_r[NUM_W].main_slot == 2'(t)) begin
        slot[t] = main_v;
      end else begin
        slot[t] = part[idx];
        idx     = idx + 1;
      end
    end
    if (dv_cls_r[NUM_W].degen) begin
      for (int t = 0; t < 4; t++) begin
        slot[t] = '0;
      end
    end
    out_nxt.q_w        = slot[0];
    out_nxt.q_x        = slot[1];
    out_nxt.q_y        = slot[2];
    out_nxt.q_z        = slot[3];
    out_nxt.degenerate = dv_cls_r[NUM_W].degen;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_v_r[NUM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

endmodule

// File: hw/rtl/rotation_matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// 3x3 rotation matrix (Q2.30) to unit quaternion (Q2.30), Shepperd's method.
//
//   port group  dir  handshake          payload
//   in_         in   in_valid/in_ready  rmq_in_t  (m00 .. m22)
//   out_        out  out_valid/out_ready rmq_out_t (q_w q_x q_y q_z degenerate)
//
// One request per cycle sustained while the output is not stalled. Requests
// pass the front register, queue, root and divider pipes and output register.
// Synchronous active-low reset clears all valid bits and queue pointers.
// An output stall freezes the back pipe; the queue and front keep accepting
// until the two-entry queue fills.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion import rmq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  rmq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output rmq_out_t out_data
);

  logic     push_valid, push_ready, pop_valid, pop_ready;
  rmq_cls_t push_data, pop_data;

  rmq_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  rmq_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  rmq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: dv/rotation_matrix_to_quaternion_test.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_test
// Drives directed and random 3x3 matrices into the converter under random
// sender gaps and receiver stalls, and checks every quaternion against a
// bit-exact fixed-point predictor kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_test;
  import rmq_pkg::*;

  localparam longint ONE_Q  = 64'sd1 << FRAC_BITS;
  localparam longint Q_MAX  = (64'sd1 << (DATA_WIDTH - 1)) - 1;
  localparam longint Q_MIN  = -(64'sd1 << (DATA_WIDTH - 1));
  localparam int     N_RAND = 1800;
  localparam int     IDLE_LIMIT = 20000;

  class quat_scoreboard;
    rmq_out_t pending[$];
    int       n_bad;
    int       n_ok;
    int       n_degen;

    function longint unsigned root_of(longint unsigned n);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function longint half_over_root(longint s, longint unsigned r);
      longint unsigned mag;
      longint unsigned q;
      mag = (s < 0) ? longint'(-s) : longint'(s);
      q = ((mag << (FRAC_BITS - 1)) + (r >> 1)) / r;
      if (q > longint'(Q_MAX) + 1) q = longint'(Q_MAX) + 1;
      return (s < 0) ? -longint'(q) : longint'(q);
    endfunction

    function fix_t clip(longint v);
      if (v > Q_MAX) v = Q_MAX;
      if (v < Q_MIN) v = Q_MIN;
      return fix_t'(v);
    endfunction

    function void note_request(rmq_in_t d);
      longint m[3][3];
      longint q[4];
      longint tr, a;
      longint unsigned r;
      int i, j, k;
      rmq_out_t e;
      m[0][0] = longint'(d.m00); m[0][1] = longint'(d.m01); m[0][2] = longint'(d.m02);
      m[1][0] = longint'(d.m10); m[1][1] = longint'(d.m11); m[1][2] = longint'(d.m12);
      m[2][0] = longint'(d.m20); m[2][1] = longint'(d.m21); m[2][2] = longint'(d.m22);
      q = '{0, 0, 0, 0};
      e.degenerate = 1'b0;
      tr = m[0][0] + m[1][1] + m[2][2];
      if (tr > 0) begin
        r = root_of(longint'(tr + ONE_Q) << FRAC_BITS);
        q[0] = (r + 1) >> 1;
        q[1] = half_over_root(m[2][1] - m[1][2], r);
        q[2] = half_over_root(m[0][2] - m[2][0], r);
        q[3] = half_over_root(m[1][0] - m[0][1], r);
      end else begin
        i = 0;
        if (m[1][1] > m[0][0]) i = 1;
        if (m[2][2] > m[i][i]) i = 2;
        j = (i + 1) % 3;
        k = (j + 1) % 3;
        a = m[i][i] - m[j][j] - m[k][k] + ONE_Q;
        if (a <= 0) begin
          e.degenerate = 1'b1;
        end else begin
          r = root_of(longint'(a) << FRAC_BITS);
          q[i + 1] = (r + 1) >> 1;
          q[0] = half_over_root(m[k][j] - m[j][k], r);
          q[j + 1] = half_over_root(m[j][i] + m[i][j], r);
          q[k + 1] = half_over_root(m[k][i] + m[i][k], r);
        end
      end
      e.q_w = clip(q[0]);
      e.q_x = clip(q[1]);
      e.q_y = clip(q[2]);
      e.q_z = clip(q[3]);
      pending.push_back(e);
    endfunction

    function void check_result(rmq_out_t got);
      rmq_out_t e;
      if (pending.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result %h", got);
        return;
      end
      e = pending.pop_front();
      if (e.degenerate) n_degen++;
      if (got.q_w !== e.q_w || got.q_x !== e.q_x || got.q_y !== e.q_y ||
          got.q_z !== e.q_z || got.degenerate !== e.degenerate) begin
        n_bad++;
        if (n_bad <= 10)
          $display("mismatch: exp w=%h x=%h y=%h z=%h dg=%b got w=%h x=%h y=%h z=%h dg=%b",
                   e.q_w, e.q_x, e.q_y, e.q_z, e.degenerate,
                   got.q_w, got.q_x, got.q_y, got.q_z, got.degenerate);
      end else begin
        n_ok++;
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  rmq_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  rmq_out_t out_data;

  quat_scoreboard sb = new();
  bit  sending_done = 1'b0;
  int  idle_cycles = 0;
  int  n_sent = 0;

  always #6 clk = ~clk;

  rotation_matrix_to_quaternion u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_request(in_data);
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // receiver stall pattern: long open stretches, bursts of stalls, random, alternating
  int stall_mode = 0;
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ~out_ready;
    endcase
  end

  function fix_t near(longint v, int spread);
    return clip_fix(v + $signed($urandom_range(0, 2 * spread)) - spread);
  endfunction

  function fix_t clip_fix(longint v);
    if (v > Q_MAX) v = Q_MAX;
    if (v < Q_MIN) v = Q_MIN;
    return fix_t'(v);
  endfunction

  // random proper rotation built from a random unit quaternion
  function rmq_in_t rand_rotation();
    real w, x, y, z, n, s;
    rmq_in_t d;
    w = $urandom_range(0, 2000) - 1000.0;
    x = $urandom_range(0, 2000) - 1000.0;
    y = $urandom_range(0, 2000) - 1000.0;
    z = $urandom_range(0, 2000) - 1000.0;
    n = $sqrt(w * w + x * x + y * y + z * z);
    if (n < 1.0) begin
      w = 1.0;
      n = 1.0;
    end
    w /= n; x /= n; y /= n; z /= n;
    s = ONE_Q;
    d.m00 = fix_t'(longint'(s * (1 - 2 * (y * y + z * z))));
    d.m01 = fix_t'(longint'(s * 2 * (x * y - z * w)));
    d.m02 = fix_t'(longint'(s * 2 * (x * z + y * w)));
    d.m10 = fix_t'(longint'(s * 2 * (x * y + z * w)));
    d.m11 = fix_t'(longint'(s * (1 - 2 * (x * x + z * z))));
    d.m12 = fix_t'(longint'(s * 2 * (y * z - x * w)));
    d.m20 = fix_t'(longint'(s * 2 * (x * z - y * w)));
    d.m21 = fix_t'(longint'(s * 2 * (y * z + x * w)));
    d.m22 = fix_t'(longint'(s * (1 - 2 * (x * x + y * y))));
    return d;
  endfunction

  task automatic send_request(rmq_in_t d);
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic send_gap();
    int g;
    g = $urandom_range(1, 6);
    in_valid <= 1'b0;
    repeat (g) @(posedge clk);
  endtask

  function rmq_in_t diag(longint a, longint b, longint c);
    rmq_in_t d;
    d = '0;
    d.m00 = clip_fix(a);
    d.m11 = clip_fix(b);
    d.m22 = clip_fix(c);
    return d;
  endfunction

  initial begin
    rmq_in_t d;
    rmq_in_t directed[$];
    int burst;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(diag(ONE_Q, ONE_Q, ONE_Q));
    directed.push_back(diag(ONE_Q, -ONE_Q, -ONE_Q));
    directed.push_back(diag(-ONE_Q, ONE_Q, -ONE_Q));
    directed.push_back(diag(-ONE_Q, -ONE_Q, ONE_Q));
    directed.push_back(diag(0, 0, 0));
    directed.push_back(diag(-ONE_Q, -ONE_Q, -ONE_Q));
    directed.push_back(diag(ONE_Q / 2, ONE_Q / 2, -ONE_Q));
    directed.push_back(diag(-ONE_Q / 2, -ONE_Q / 2, -ONE_Q / 2));
    directed.push_back(diag(-ONE_Q, 0, 0));
    directed.push_back(diag(Q_MIN, Q_MIN, Q_MIN));
    directed.push_back(diag(Q_MAX, Q_MAX, Q_MAX));
    directed.push_back(diag(Q_MAX, Q_MIN, Q_MIN));
    directed.push_back(diag(Q_MIN, Q_MIN, Q_MAX));
    directed.push_back(diag(1, 0, 0));
    directed.push_back(diag(0, 0, 1));
    d = '1;
    directed.push_back(d);
    d = {9{fix_t'(Q_MAX)}};
    directed.push_back(d);
    d = {9{fix_t'(Q_MIN)}};
    directed.push_back(d);
    d = diag(Q_MIN, Q_MIN, Q_MAX);
    d.m01 = fix_t'(Q_MAX); d.m10 = fix_t'(Q_MAX);
    d.m02 = fix_t'(Q_MIN); d.m20 = fix_t'(Q_MAX);
    directed.push_back(d);
    d = diag(1, 0, 0);
    d.m21 = fix_t'(Q_MAX); d.m12 = fix_t'(Q_MIN);
    directed.push_back(d);
    foreach (directed[n]) begin
      send_request(directed[n]);
      if ($urandom_range(0, 2) == 0) send_gap();
    end

    while (n_sent < N_RAND + directed.size()) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: d = rand_rotation();
          5: begin
            d = rand_rotation();
            d.m00 = near(longint'(d.m00), 4);
            d.m11 = near(longint'(d.m11), 4);
            d.m22 = near(longint'(d.m22), 4);
          end
          6: begin
            // ties among near-equal diagonal entries around -1 (trace near -3)
            d = diag(longint'(near(-ONE_Q, 3)), longint'(near(-ONE_Q, 3)),
                     longint'(near(-ONE_Q, 3)));
            d.m01 = $urandom; d.m10 = $urandom;
          end
          7: d = diag(longint'(near(0, 2)), longint'(near(0, 2)), longint'(near(0, 2)));
          default: begin
            d = {$urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom};
          end
        endcase
        send_request(d);
      end
      if ($urandom_range(0, 3) != 0) send_gap();
    end
    in_valid <= 1'b0;
    sending_done = 1'b1;
  end

  initial begin
    @(posedge clk);
    while (!(sending_done && sb.pending.size() == 0) && idle_cycles < IDLE_LIMIT)
      @(posedge clk);
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      repeat (4 * DATA_WIDTH + 20) @(posedge clk);
      $display("sent %0d matrices, %0d quaternions matched, %0d degenerate",
               n_sent, sb.n_ok, sb.n_degen);
      $display("mismatches or stray results: %0d", sb.n_bad);
      if (sb.n_bad == 0 && sb.pending.size() == 0) begin
        $display("end of test: clean");
      end else begin
        $display("end of test: mismatches");
      end
      $finish;
    end
  end

endmodule
